[hdl/i2cram_pkg.sv]
// Shared types, constants and slot decode for the I2C register access master.
// Used by i2cram_front, i2cram_back and i2c_register_access_master.
package i2cram_pkg;

  localparam int TickCountBits = 8;
  localparam int CmpW          = ((TickCountBits > 8) ? TickCountBits : 8) + 1;
  localparam logic [TickCountBits-1:0] TickMax = {TickCountBits{1'b1}};

  localparam logic [7:0] WriteSlots = 8'd76;
  localparam logic [7:0] ReadSlots  = 8'd97;
  localparam logic [7:0] PhaseMask  = 8'hFF;

  localparam logic [6:0] DevAddrReset    = 7'd72;
  localparam logic [7:0] PhaseTicksReset = 8'd4;

  // Queue depth shared by the command queue and the result queue
  localparam int QDepth = 2;
  localparam int PtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW   = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    CFG_DEV_ADDR    = 1'b0,
    CFG_PHASE_TICKS = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_WRITE,
    CMD_READ
  } cmd_e;

  typedef enum logic [1:0] {
    RX_NONE,
    RX_HIGH,
    RX_LOW
  } rx_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  reg_pointer;
    logic [15:0] write_value;
    logic        sda_in;
  } item_t;

  typedef struct packed {
    logic        scl_drive_low;
    logic        sda_drive_low;
    logic        busy;
    logic [15:0] read_data;
    logic        done;
  } res_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    rx_e        rx;
    logic [4:0] rx_slot;
  } slot_t;

  // Levels for one slot of a transmitted byte: pair = s>>1, even slot = SCL low.
  function automatic logic [1:0] tx_levels(logic [7:0] tx_byte, logic [4:0] s);
    logic [3:0] pair;
    logic       scl;
    logic       sda;
    pair = s[4:1];
    scl  = s[0];
    if (pair < 4'd8) begin
      sda = ~tx_byte[3'd7 - pair[2:0]];
    end else begin
      sda = 1'b0;
    end
    return {~scl, sda};
  endfunction

  function automatic slot_t slot_decode(logic rd, logic [7:0] p, logic [7:0] addr,
                                        logic [7:0] ptr, logic [15:0] val);
    slot_t      r;
    logic [7:0] q;
    logic [4:0] s;
    logic [7:0] tx_byte;
    logic [1:0] lv;
    r  = '{scl: 1'b0, sda: 1'b0, rx: RX_NONE, rx_slot: 5'd0};
    q  = p - 8'd1;
    // byte index and slot within the byte without a divider
    priority if (q < 8'd18) begin
      s = q[4:0];
      tx_byte = addr;
    end else if (q < 8'd36) begin
      s = 5'(q - 8'd18);
      tx_byte = ptr;
    end else if (q < 8'd54) begin
      s = 5'(q - 8'd36);
      tx_byte = val[15:8];
    end else begin
      s = 5'(q - 8'd54);
      tx_byte = val[7:0];
    end
    lv = tx_levels(tx_byte, s);
    if (p == 8'd0) begin
      r.scl = 1'b0; r.sda = 1'b1;
    end else if (!rd) begin
      priority if (p <= 8'd72) begin
        r.scl = lv[1]; r.sda = lv[0];
      end else if (p == 8'd73) begin
        r.scl = 1'b1; r.sda = 1'b1;
      end else if (p == 8'd74) begin
        r.scl = 1'b0; r.sda = 1'b1;
      end else begin
        r.scl = 1'b0; r.sda = 1'b0;
      end
    end else begin
      priority if (p <= 8'd36) begin
        r.scl = lv[1]; r.sda = lv[0];
      end else if (p == 8'd37) begin
        r.scl = 1'b1; r.sda = 1'b0;
      end else if (p == 8'd38) begin
        r.scl = 1'b0; r.sda = 1'b0;
      end else if (p == 8'd39) begin
        r.scl = 1'b0; r.sda = 1'b1;
      end else if (p <= 8'd57) begin
        lv = tx_levels(addr | 8'd1, 5'(p - 8'd40));
        r.scl = lv[1]; r.sda = lv[0];
      end else if (p <= 8'd93) begin
        if (p <= 8'd75) begin
          r.rx = RX_HIGH;
          r.rx_slot = 5'(p - 8'd58);
        end else begin
          r.rx = RX_LOW;
          r.rx_slot = 5'(p - 8'd76);
        end
        r.scl = ~r.rx_slot[0];
        // master ACK after the high byte, NACK after the low byte
        if (r.rx_slot < 5'd16) begin
          r.sda = 1'b0;
        end else begin
          r.sda = (r.rx == RX_HIGH);
        end
      end else if (p == 8'd94) begin
        r.scl = 1'b1; r.sda = 1'b1;
      end else if (p == 8'd95) begin
        r.scl = 1'b0; r.sda = 1'b1;
      end else begin
        r.scl = 1'b0; r.sda = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

[hdl/i2cram_front.sv]
// Front end: accepts input transactions, classifies the op code and queues
// them for the sequencer. Depends on i2cram_pkg.
module i2cram_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          op_i,
  input  logic [7:0]          reg_pointer_i,
  input  logic [15:0]         write_value_i,
  input  logic                sda_in_i,
  output logic                item_valid_o,
  output i2cram_pkg::item_t   item_o,
  input  logic                item_pop_i
);
  import i2cram_pkg::*;

  item_t          mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic           do_push;
  logic           do_pop;
  item_t          in_item;

  always_comb begin
    in_item.reg_pointer = reg_pointer_i;
    in_item.write_value = write_value_i;
    in_item.sda_in      = sda_in_i;
    unique case (op_e'(op_i))
      OP_WRITE: in_item.cmd = CMD_WRITE;
      OP_READ:  in_item.cmd = CMD_READ;
      default:  in_item.cmd = CMD_TICK;
    endcase
  end

  assign full         = (cnt_q == CntW'(QDepth));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign do_push      = push && !full;
  assign do_pop       = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

[hdl/i2cram_back.sv]
// Back end: bus waveform sequencer, one tick per queued transaction, with a
// result queue toward the consumer. Depends on i2cram_pkg.
module i2cram_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [6:0]          dev_addr_i,
  input  logic [7:0]          phase_ticks_i,
  input  logic                item_valid_i,
  input  i2cram_pkg::item_t   item_i,
  output logic                item_pop_o,
  output logic                empty,
  input  logic                pop,
  output i2cram_pkg::res_t    res_o
);
  import i2cram_pkg::*;

  logic                     active_q, active_d;
  logic                     is_read_q, is_read_d;
  logic [7:0]               ptr_q, ptr_d;
  logic [15:0]              val_q, val_d;
  logic [7:0]               phase_q, phase_d;
  logic [TickCountBits-1:0] tick_q, tick_d;
  logic [7:0]               shift_q, shift_d;
  logic [15:0]              rdata_q, rdata_d;

  res_t            rmem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  logic                     step;
  logic                     start;
  logic                     act_e, rd_e;
  logic [15:0]              val_e;
  logic [7:0]               phase_e;
  logic [TickCountBits-1:0] tick_e;
  logic [7:0]               shift_e;
  logic [7:0]               phase_nx;
  logic [7:0]               total;
  logic                     slot_end;
  logic [7:0]               shift_nx;
  slot_t                    sl;
  res_t                     res;
  logic                     do_pop;

  assign step       = item_valid_i && (cnt_q != CntW'(QDepth));
  assign item_pop_o = step;
  assign start      = !active_q && (item_i.cmd == CMD_WRITE || item_i.cmd == CMD_READ);

  always_comb begin
    act_e   = active_q || start;
    rd_e    = start ? (item_i.cmd == CMD_READ) : is_read_q;
    val_e   = start ? item_i.write_value : val_q;
    phase_e = start ? 8'd0 : phase_q;
    tick_e  = start ? '0 : tick_q;
    shift_e = start ? 8'd0 : shift_q;
    total   = rd_e ? ReadSlots : WriteSlots;
    sl      = slot_decode(rd_e, phase_e, {dev_addr_i, 1'b0},
                          start ? item_i.reg_pointer : ptr_q, val_e);
    slot_end = ((CmpW'(tick_e) + CmpW'(1)) >= CmpW'(phase_ticks_i)) || (tick_e == TickMax);
    phase_nx = (phase_e + 8'd1) & PhaseMask;
    shift_nx = {shift_e[6:0], item_i.sda_in};

    active_d  = active_q;
    is_read_d = is_read_q;
    ptr_d     = ptr_q;
    val_d     = val_q;
    phase_d   = phase_q;
    tick_d    = tick_q;
    shift_d   = shift_q;
    rdata_d   = rdata_q;
    res       = '0;

    if (step) begin
      if (start) begin
        active_d  = 1'b1;
        is_read_d = rd_e;
        ptr_d     = item_i.reg_pointer;
        val_d     = item_i.write_value;
        phase_d   = 8'd0;
        tick_d    = '0;
        shift_d   = 8'd0;
      end
      if (act_e) begin
        res.scl_drive_low = sl.scl;
        res.sda_drive_low = sl.sda;
        if (slot_end) begin
          tick_d = '0;
          // sample on the last tick of a data high slot
          if (sl.rx != RX_NONE && sl.rx_slot[0] && sl.rx_slot < 5'd16) begin
            shift_d = shift_nx;
            if (sl.rx_slot[3:1] == 3'd7) begin
              if (sl.rx == RX_HIGH) begin
                val_d = {shift_nx, 8'h00};
              end else begin
                rdata_d = {val_e[15:8], shift_nx};
              end
            end
          end
          phase_d = phase_nx;
          if (phase_nx >= total) begin
            active_d = 1'b0;
            phase_d  = 8'd0;
            res.done = 1'b1;
          end
        end else begin
          tick_d = tick_e + TickCountBits'(1);
        end
      end
      res.busy      = active_d;
      res.read_data = rdata_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      is_read_q <= 1'b0;
      ptr_q     <= '0;
      val_q     <= '0;
      phase_q   <= '0;
      tick_q    <= '0;
      shift_q   <= '0;
      rdata_q   <= '0;
    end else begin
      active_q  <= active_d;
      is_read_q <= is_read_d;
      ptr_q     <= ptr_d;
      val_q     <= val_d;
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      shift_q   <= shift_d;
      rdata_q   <= rdata_d;
    end
  end

  // result queue
  assign empty  = (cnt_q == '0);
  assign do_pop = pop && !empty;
  assign res_o  = rmem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (step) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (step && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !step) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      rmem_q[wr_ptr_q] <= res;
    end
  end

endmodule

[hdl/i2c_register_access_master.sv]
// I2C register access master: one result per accepted tick transaction.
// A tick is held in the command queue, stepped by the sequencer and written to the result queue.
// Throughput: one tick per cycle while the result queue is not full, set by the single-step sequencer update.
// Each queue holds 2 entries; full/empty decouple both sides.
// rst_ni clears queues and sequencer; config resets to address 72, 4 ticks.
// Depends on i2cram_pkg, i2cram_front and i2cram_back.
module i2c_register_access_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op_i,
  input  logic [7:0]  reg_pointer_i,
  input  logic [15:0] write_value_i,
  input  logic        sda_in_i,
  output logic        empty,
  input  logic        pop,
  output logic        scl_drive_low_o,
  output logic        sda_drive_low_o,
  output logic        busy_res_o,
  output logic [15:0] read_data_o,
  output logic        done_res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import i2cram_pkg::*;

  logic [6:0] dev_addr_q;
  logic [7:0] phase_ticks_q;
  logic       item_valid;
  logic       item_pop;
  item_t      item;
  res_t       res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DevAddrReset;
      phase_ticks_q <= PhaseTicksReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DEV_ADDR:    dev_addr_q    <= cfg_data_i[6:0];
        CFG_PHASE_TICKS: phase_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  i2cram_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .op_i          (op_i),
    .reg_pointer_i (reg_pointer_i),
    .write_value_i (write_value_i),
    .sda_in_i      (sda_in_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_pop_i    (item_pop)
  );

  i2cram_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dev_addr_i    (dev_addr_q),
    .phase_ticks_i (phase_ticks_q),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .empty         (empty),
    .pop           (pop),
    .res_o         (res)
  );

  assign scl_drive_low_o = res.scl_drive_low;
  assign sda_drive_low_o = res.sda_drive_low;
  assign busy_res_o      = res.busy;
  assign read_data_o     = res.read_data;
  assign done_res_o      = res.done;

`ifndef SYNTH
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && done_res_o) |-> !busy_res_o)
    else $error("done flagged while still busy");

  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !busy_res_o) |-> (!scl_drive_low_o && !sda_drive_low_o))
    else $error("bus driven outside a transaction");

  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("command queue filled without a push");
`endif

endmodule

[tb/sv/i2c_access_checker.sv]
// Scoreboard for the I2C register access master: predicts the bus levels of
// every accepted tick and compares them with the result queue output.
// Depends on i2cram_pkg for the item, result and config encodings.
module i2c_access_checker
  import i2cram_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [1:0]  op_i,
  input  logic [7:0]  reg_pointer_i,
  input  logic [15:0] write_value_i,
  input  logic        sda_in_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic        scl_drive_low_i,
  input  logic        sda_drive_low_i,
  input  logic        busy_res_i,
  input  logic [15:0] read_data_i,
  input  logic        done_res_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o
);

  // shadow copy of the configuration and the sequencer
  logic [6:0]  dev_addr;
  logic [7:0]  half_ticks;
  logic        run;
  logic        rd_mode;
  logic [7:0]  ptr_l;
  logic [15:0] val_l;
  logic [7:0]  slot;
  logic [7:0]  tcnt;
  logic [7:0]  shreg;
  logic [15:0] rd_word;

  res_t pending_levels[$];

  initial begin
    errors_o  = 0;
    checked_o = 0;
    pending_o = 0;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    errors_o++;
  endtask

  task automatic check_field(string field, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                checked_o, field, got, want));
    end
  endtask

  // One tick of the bus sequencer; returns the line levels and status after it.
  function automatic res_t advance_master(op_e op, logic [7:0] ptr, logic [15:0] val,
                                          logic sda_bit);
    res_t        r;
    int          p;
    int          s;
    int          rx_s;
    int          total;
    logic [7:0]  addr_w;
    logic [7:0]  tx;
    logic        scl;
    logic        sda;
    logic        done;
    rx_e         rx_kind;
    scl     = 1'b0;
    sda     = 1'b0;
    done    = 1'b0;
    rx_kind = RX_NONE;
    rx_s    = 0;
    tx      = 8'h00;
    if (!run && (op == OP_WRITE || op == OP_READ)) begin
      run     = 1'b1;
      rd_mode = (op == OP_READ);
      ptr_l   = ptr;
      val_l   = val;
      slot    = 8'd0;
      tcnt    = 8'd0;
      shreg   = 8'd0;
    end
    if (run) begin
      p      = slot;
      addr_w = {dev_addr, 1'b0};
      total  = rd_mode ? int'(ReadSlots) : int'(WriteSlots);
      s      = -1;  // >= 0 marks a slot of a transmitted byte
      if (p == 0) begin
        scl = 1'b0; sda = 1'b1;
      end else if (!rd_mode) begin
        if (p <= 72) begin
          s = (p - 1) % 18;
          case ((p - 1) / 18)
            0:       tx = addr_w;
            1:       tx = ptr_l;
            2:       tx = val_l[15:8];
            default: tx = val_l[7:0];
          endcase
        end else if (p == 73) begin
          scl = 1'b1; sda = 1'b1;
        end else if (p == 74) begin
          scl = 1'b0; sda = 1'b1;
        end else begin
          scl = 1'b0; sda = 1'b0;
        end
      end else begin
        if (p <= 36) begin
          s  = (p - 1) % 18;
          tx = ((p - 1) / 18 == 0) ? addr_w : ptr_l;
        end else if (p == 37) begin
          scl = 1'b1; sda = 1'b0;
        end else if (p == 38) begin
          scl = 1'b0; sda = 1'b0;
        end else if (p == 39) begin
          // repeated start: SCL released before SDA is pulled
          scl = 1'b0; sda = 1'b1;
        end else if (p <= 57) begin
          s  = p - 40;
          tx = addr_w | 8'h01;
        end else if (p <= 93) begin
          rx_s    = (p - 58) % 18;
          rx_kind = (p <= 75) ? RX_HIGH : RX_LOW;
          scl     = (rx_s % 2 == 0);
          // master ACK after the high byte, NACK after the low byte
          sda     = (rx_s / 2 < 8) ? 1'b0 : (rx_kind == RX_HIGH);
        end else if (p == 94) begin
          scl = 1'b1; sda = 1'b1;
        end else if (p == 95) begin
          scl = 1'b0; sda = 1'b1;
        end else begin
          scl = 1'b0; sda = 1'b0;
        end
      end
      if (s >= 0) begin
        scl = (s % 2 == 0);
        sda = (s / 2 < 8) ? ~tx[7 - s / 2] : 1'b0;
      end
      if (int'(tcnt) + 1 >= int'(half_ticks) || tcnt == TickMax) begin
        tcnt = 8'd0;
        if (rx_kind != RX_NONE && rx_s % 2 == 1 && rx_s / 2 < 8) begin
          shreg = {shreg[6:0], sda_bit};
          if (rx_s / 2 == 7) begin
            if (rx_kind == RX_HIGH) val_l = {shreg, 8'h00};
            else rd_word = {val_l[15:8], shreg};
          end
        end
        slot = slot + 8'd1;
        if (int'(slot) >= total) begin
          run  = 1'b0;
          slot = 8'd0;
          done = 1'b1;
        end
      end else begin
        tcnt = tcnt + 8'd1;
      end
    end
    r.scl_drive_low = scl;
    r.sda_drive_low = sda;
    r.busy          = run;
    r.read_data     = rd_word;
    r.done          = done;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    res_t want;
    if (!rst_ni) begin
      dev_addr   = DevAddrReset;
      half_ticks = PhaseTicksReset;
      run        = 1'b0;
      rd_mode    = 1'b0;
      ptr_l      = 8'd0;
      val_l      = 16'd0;
      slot       = 8'd0;
      tcnt       = 8'd0;
      shreg      = 8'd0;
      rd_word    = 16'd0;
      pending_levels.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_DEV_ADDR:    dev_addr   = cfg_data_i[6:0];
          CFG_PHASE_TICKS: half_ticks = cfg_data_i;
          default: ;
        endcase
      end
      if (pop_i && !empty_i) begin
        if (pending_levels.size() == 0) begin
          report_mismatch("result transaction with no tick outstanding");
        end else begin
          want = pending_levels.pop_front();
          check_field("scl_drive_low", 16'(scl_drive_low_i), 16'(want.scl_drive_low));
          check_field("sda_drive_low", 16'(sda_drive_low_i), 16'(want.sda_drive_low));
          check_field("busy_res", 16'(busy_res_i), 16'(want.busy));
          check_field("read_data", read_data_i, want.read_data);
          check_field("done_res", 16'(done_res_i), 16'(want.done));
          checked_o++;
        end
      end
      if (push_i && !full_i) begin
        pending_levels.push_back(advance_master(op_e'(op_i), reg_pointer_i,
                                                write_value_i, sda_in_i));
      end
      pending_o <= pending_levels.size();
    end
  end

endmodule

[tb/sv/testbench.sv]
// Top of the I2C register access master bench: clock, reset, tick and config
// stimulus, random stalls on both queues, and the final verdict.
// Depends on i2cram_pkg, i2c_register_access_master and i2c_access_checker.
module testbench;
  import i2cram_pkg::*;

  localparam int CycleLimit = 4_000_000;
  localparam int RandomTicks = 240;

  // SDA levels that the bench returns while a transaction runs
  localparam int SdaLow    = 0;
  localparam int SdaHigh   = 1;
  localparam int SdaRandom = 2;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic [1:0]  op = OP_TICK;
  logic [7:0]  reg_pointer = 8'd0;
  logic [15:0] write_value = 16'd0;
  logic        sda_in = 1'b0;
  logic        pop = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [0:0]  cfg_index = CFG_DEV_ADDR;
  logic [7:0]  cfg_data = 8'd0;

  logic        full;
  logic        empty;
  logic        scl_drive_low;
  logic        sda_drive_low;
  logic        busy_res;
  logic [15:0] read_data;
  logic        done_res;
  logic        cfg_ready;

  int errors;
  int pending;
  int checked;
  int cycles = 0;
  int n_ticks = 0;
  int n_writes = 0;
  int n_reads = 0;
  bit push_gaps = 1'b1;
  bit pop_gaps = 1'b1;
  logic [7:0] cur_ticks = PhaseTicksReset;

  i2c_register_access_master DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .op_i            (op),
    .reg_pointer_i   (reg_pointer),
    .write_value_i   (write_value),
    .sda_in_i        (sda_in),
    .empty           (empty),
    .pop             (pop),
    .scl_drive_low_o (scl_drive_low),
    .sda_drive_low_o (sda_drive_low),
    .busy_res_o      (busy_res),
    .read_data_o     (read_data),
    .done_res_o      (done_res),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  i2c_access_checker scoreboard (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_i          (full),
    .op_i            (op),
    .reg_pointer_i   (reg_pointer),
    .write_value_i   (write_value),
    .sda_in_i        (sda_in),
    .empty_i         (empty),
    .pop_i           (pop),
    .scl_drive_low_i (scl_drive_low),
    .sda_drive_low_i (sda_drive_low),
    .busy_res_i      (busy_res),
    .read_data_i     (read_data),
    .done_res_i      (done_res),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .errors_o        (errors),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stalls, with long stretches of none
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    pop <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if ($urandom_range(0, 39) == 0) pop_gaps = !pop_gaps;
        stall = pop_gaps ? $urandom_range(0, 13) : 0;
        if (stall > 0) begin
          pop <= 1'b0;
          repeat (stall) @(posedge clk_i);
          pop <= 1'b1;
        end
      end
    end
  end

  function automatic logic sda_level(int mode);
    if (mode == SdaLow) return 1'b0;
    if (mode == SdaHigh) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  // push is left high after acceptance so back-to-back ticks need no toggle
  task automatic send_tick(op_e op_v, logic [7:0] ptr_v, logic [15:0] val_v, logic sda_v);
    int gap;
    if ($urandom_range(0, 39) == 0) push_gaps = !push_gaps;
    gap = push_gaps ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    op          <= op_v;
    reg_pointer <= ptr_v;
    write_value <= val_v;
    sda_in      <= sda_v;
    do @(posedge clk_i); while (full);
    n_ticks++;
  endtask

  task automatic idle_ticks(int n);
    for (int k = 0; k < n; k++) begin
      send_tick(($urandom_range(0, 3) == 0) ? OP_NONE : OP_TICK, 8'($urandom),
                16'($urandom), sda_level(SdaRandom));
    end
  endtask

  // Command tick plus exactly enough ticks to reach its done tick; stray
  // commands mixed in must be ignored while the bus is busy.
  task automatic run_transaction(op_e cmd, logic [7:0] ptr_v, logic [15:0] val_v,
                                 int sda_mode);
    int   span;
    op_e  stray;
    span = ((cmd == OP_READ) ? int'(ReadSlots) : int'(WriteSlots)) *
           ((cur_ticks == 8'd0) ? 1 : int'(cur_ticks));
    send_tick(cmd, ptr_v, val_v, sda_level(sda_mode));
    for (int k = 1; k < span; k++) begin
      stray = ($urandom_range(0, 15) == 0) ? op_e'($urandom_range(0, 3)) : OP_TICK;
      send_tick(stray, 8'($urandom), 16'($urandom), sda_level(sda_mode));
    end
    if (cmd == OP_READ) n_reads++;
    else n_writes++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] data);
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PHASE_TICKS) cur_ticks = data;
  endtask

  initial begin
    int random_base;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: unused op code, field extremes, one full read
    send_tick(OP_NONE, 8'hFF, 16'hFFFF, 1'b1);
    send_tick(OP_TICK, 8'h00, 16'h0000, 1'b0);
    run_transaction(OP_READ, 8'hA5, 16'h5A5A, SdaRandom);
    idle_ticks(2);

    // lowest address, zero half-phase length, field extremes, fixed SDA patterns
    write_reg(CFG_DEV_ADDR, 8'h00);
    write_reg(CFG_PHASE_TICKS, 8'h00);
    run_transaction(OP_WRITE, 8'h00, 16'h0000, SdaRandom);
    run_transaction(OP_WRITE, 8'hFF, 16'hFFFF, SdaRandom);
    run_transaction(OP_READ, 8'h00, 16'h0000, SdaHigh);
    run_transaction(OP_READ, 8'hFF, 16'hFFFF, SdaLow);

    // top address bit pattern with bit 7 set, which the block drops
    write_reg(CFG_DEV_ADDR, 8'hFF);
    write_reg(CFG_PHASE_TICKS, 8'h01);
    run_transaction(OP_READ, 8'($urandom), 16'($urandom), SdaRandom);
    run_transaction(OP_WRITE, 8'($urandom), 16'($urandom), SdaRandom);

    random_base = n_ticks;
    while (n_ticks - random_base < RandomTicks) begin
      if ($urandom_range(0, 1)) write_reg(CFG_DEV_ADDR, 8'($urandom));
      write_reg(CFG_PHASE_TICKS, 8'($urandom_range(0, 2)));
      if ($urandom_range(0, 4) == 0) begin
        idle_ticks($urandom_range(1, 8));
      end else begin
        run_transaction($urandom_range(0, 1) ? OP_READ : OP_WRITE, 8'($urandom),
                        16'($urandom), SdaRandom);
        idle_ticks($urandom_range(0, 3));
      end
    end

    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (16) @(posedge clk_i);

    $display("Ran %0d register writes and %0d register reads over %0d ticks,",
             n_writes, n_reads, n_ticks);
    $display("at zero, one, two and the reset half-phase lengths; %0d results compared.",
             checked);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/i2cram_pkg.sv
hdl/i2cram_front.sv
hdl/i2cram_back.sv
hdl/i2c_register_access_master.sv
tb/sv/i2c_access_checker.sv
tb/sv/testbench.sv
